// ===== hdl/pitb_pkg.sv =====
// package with widths, sign codes and helper functions for the triangle test
package pitb_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int AW = PW + 1;
  localparam int SW = AW + 2;
  localparam int MW = SW - 1;
  localparam int WW = FRAC_BITS + 1;

  typedef enum logic [1:0] {
    SGN_ZERO,
    SGN_POS,
    SGN_NEG
  } sign_t;

  // area sign with simulation of simplicity tie breaking
  function automatic sign_t orient_sign(input logic signed [AW-1:0] area,
                                        input logic signed [DW-1:0] px,
                                        input logic signed [DW-1:0] py,
                                        input logic signed [DW-1:0] qx,
                                        input logic signed [DW-1:0] qy);
    sign_t s;
    if (area > 0) begin
      s = SGN_POS;
    end else if (area < 0) begin
      s = SGN_NEG;
    end else if (qy > py) begin
      s = SGN_POS;
    end else if (qy < py) begin
      s = SGN_NEG;
    end else if (px > qx) begin
      s = SGN_POS;
    end else if (px < qx) begin
      s = SGN_NEG;
    end else begin
      s = SGN_ZERO;
    end
    return s;
  endfunction

  function automatic logic [MW-1:0] area_mag(input logic signed [AW-1:0] a);
    logic signed [AW:0] e;
    e = {a[AW-1], a};
    return (e < 0) ? MW'(-e) : MW'(e);
  endfunction

endpackage

// ===== hdl/point_in_triangle_barycentric.sv =====
// top level: pipelined point in triangle test with barycentric weights
//
// usage: while in_stall is low, one transaction per cycle on the in_ channel carries a query point and
// three vertices; each accepted transaction yields exactly one transaction on
// the out_ channel, in order: the inside flag and three Q1.16 weights (zero
// when outside)
// pipeline: vertex shift, six 17x17 products, areas and tie-broken signs, sum
// and magnitudes, then one restoring division bit per stage for all three
// weights at once; there are 4 + 16 = 20 register stages
// throughput: one transaction per cycle while the pipeline is not stalled, the divider being fully pipelined
// stall: the whole pipeline holds while out_valid is high and out_stall is
// high; in_stall is raised only then, bubbles are not squeezed out
// reset: rst_n low clears every stage valid bit; payload registers are not
// reset; no clearing pass is needed
//
// constants come from pitb_pkg
module point_in_triangle_barycentric (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [pitb_pkg::COORD_BITS-1:0] in_query_x,
  input  logic signed [pitb_pkg::COORD_BITS-1:0] in_query_y,
  input  logic signed [pitb_pkg::COORD_BITS-1:0] in_vert1_x,
  input  logic signed [pitb_pkg::COORD_BITS-1:0] in_vert1_y,
  input  logic signed [pitb_pkg::COORD_BITS-1:0] in_vert2_x,
  input  logic signed [pitb_pkg::COORD_BITS-1:0] in_vert2_y,
  input  logic signed [pitb_pkg::COORD_BITS-1:0] in_vert3_x,
  input  logic signed [pitb_pkg::COORD_BITS-1:0] in_vert3_y,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_inside_res,
  output logic [pitb_pkg::WW-1:0]               out_weight_first,
  output logic [pitb_pkg::WW-1:0]               out_weight_second,
  output logic [pitb_pkg::WW-1:0]               out_weight_third
);
  import pitb_pkg::*;

  logic en;

  // stage 1: shifted vertices
  logic              v1_r;
  logic signed [DW-1:0] x_r [3];
  logic signed [DW-1:0] y_r [3];

  // stage 2: products
  logic              v2_r;
  logic signed [DW-1:0] x2_r [3];
  logic signed [DW-1:0] y2_r [3];
  logic signed [PW-1:0] pa_r [3];
  logic signed [PW-1:0] pb_r [3];

  // stage 3: areas and signs
  logic              v3_r;
  logic signed [AW-1:0] a_r [3];
  sign_t             s_r [3];

  // divider pipeline, index 0 loaded by stage 4
  logic              dv_r   [FRAC_BITS+1];
  logic              din_r  [FRAC_BITS+1];
  logic [MW-1:0]     dden_r [FRAC_BITS+1];
  logic [MW-1:0]     drem_r [FRAC_BITS+1][3];
  logic [FRAC_BITS-1:0] dq_r [FRAC_BITS+1][3];
  logic              dfull_r [FRAC_BITS+1][3];

  logic signed [SW-1:0] sum_c;
  logic [MW-1:0]        smag_c;
  logic [MW-1:0]        amag_c [3];
  logic                 ins_c;

  assign en       = !(dv_r[FRAC_BITS] && out_stall);
  assign in_stall = !en;

  always_comb begin
    sum_c = SW'(a_r[0]) + SW'(a_r[1]) + SW'(a_r[2]);
    smag_c = (sum_c < 0) ? MW'(-sum_c) : MW'(sum_c);
    for (int i = 0; i < 3; i++) begin
      amag_c[i] = area_mag(a_r[i]);
    end
    ins_c = (s_r[0] != SGN_ZERO) && (s_r[1] == s_r[0]) && (s_r[2] == s_r[0]) &&
            (sum_c != 0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      for (int k = 0; k <= FRAC_BITS; k++) begin
        dv_r[k] <= 1'b0;
      end
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      dv_r[0] <= v3_r;
      for (int k = 1; k <= FRAC_BITS; k++) begin
        dv_r[k] <= dv_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= DW'(in_vert1_x) - DW'(in_query_x);
      y_r[0] <= DW'(in_vert1_y) - DW'(in_query_y);
      x_r[1] <= DW'(in_vert2_x) - DW'(in_query_x);
      y_r[1] <= DW'(in_vert2_y) - DW'(in_query_y);
      x_r[2] <= DW'(in_vert3_x) - DW'(in_query_x);
      y_r[2] <= DW'(in_vert3_y) - DW'(in_query_y);

      for (int i = 0; i < 3; i++) begin
        x2_r[i] <= x_r[i];
        y2_r[i] <= y_r[i];
      end
      // area i uses vertices p=(i+1)%3, q=(i+2)%3: py*qx - px*qy
      pa_r[0] <= y_r[1] * x_r[2];
      pb_r[0] <= x_r[1] * y_r[2];
      pa_r[1] <= y_r[2] * x_r[0];
      pb_r[1] <= x_r[2] * y_r[0];
      pa_r[2] <= y_r[0] * x_r[1];
      pb_r[2] <= x_r[0] * y_r[1];

      for (int i = 0; i < 3; i++) begin
        a_r[i] <= AW'(pa_r[i]) - AW'(pb_r[i]);
      end
      s_r[0] <= orient_sign(AW'(pa_r[0]) - AW'(pb_r[0]), x2_r[1], y2_r[1], x2_r[2], y2_r[2]);
      s_r[1] <= orient_sign(AW'(pa_r[1]) - AW'(pb_r[1]), x2_r[2], y2_r[2], x2_r[0], y2_r[0]);
      s_r[2] <= orient_sign(AW'(pa_r[2]) - AW'(pb_r[2]), x2_r[0], y2_r[0], x2_r[1], y2_r[1]);

      din_r[0]  <= ins_c;
      dden_r[0] <= smag_c;
      for (int i = 0; i < 3; i++) begin
        drem_r[0][i]  <= amag_c[i];
        dq_r[0][i]    <= '0;
        dfull_r[0][i] <= (amag_c[i] >= smag_c);
      end

      for (int k = 1; k <= FRAC_BITS; k++) begin
        din_r[k]  <= din_r[k-1];
        dden_r[k] <= dden_r[k-1];
        for (int i = 0; i < 3; i++) begin
          dfull_r[k][i] <= dfull_r[k-1][i];
          if ({drem_r[k-1][i], 1'b0} >= {1'b0, dden_r[k-1]}) begin
            drem_r[k][i] <= MW'({drem_r[k-1][i], 1'b0} - {1'b0, dden_r[k-1]});
            dq_r[k][i]   <= {dq_r[k-1][i][FRAC_BITS-2:0], 1'b1};
          end else begin
            drem_r[k][i] <= MW'({drem_r[k-1][i], 1'b0});
            dq_r[k][i]   <= {dq_r[k-1][i][FRAC_BITS-2:0], 1'b0};
          end
        end
      end
    end
  end

  logic [WW-1:0] w_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!din_r[FRAC_BITS]) begin
        w_c[i] = '0;
      end else if (dfull_r[FRAC_BITS][i]) begin
        w_c[i] = WW'(1) << FRAC_BITS;
      end else begin
        w_c[i] = {1'b0, dq_r[FRAC_BITS][i]};
      end
    end
  end

  assign out_valid         = dv_r[FRAC_BITS];
  assign out_inside_res    = din_r[FRAC_BITS];
  assign out_weight_first  = w_c[0];
  assign out_weight_second = w_c[1];
  assign out_weight_third  = w_c[2];

`ifndef SYNTHESIS
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_inside_res |->
      out_weight_first == '0 && out_weight_second == '0 && out_weight_third == '0)
    else $error("outside transaction with nonzero weight");

  a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_inside_res |->
      ((WW+2)'(out_weight_first) + (WW+2)'(out_weight_second) +
       (WW+2)'(out_weight_third)) <= ((WW+2)'(1) << FRAC_BITS))
    else $error("weights sum above one");

  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall not tied to output stall");
`endif

endmodule
